### sv/drps_pkg.sv
// shared types and constants for the dram request picker
// no dependencies
package drps_pkg;

  localparam int SLOT_W       = 5;
  localparam int CLOCK_W      = 32;
  localparam int LIMIT_W      = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [LIMIT_W-1:0] STARVE_LIMIT_RESET = LIMIT_W'(200);

  // one classified buffer entry as it travels from front to back
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [CLOCK_W-1:0] arrival;
    logic               ready;
    logic               starved;
    logic               first;
    logic               last;
  } entry_t;

endpackage

### sv/drps_front.sv
// front part: accepts buffer entries, latches the pick clock, marks starving entries
// depends on drps_pkg
module drps_front
  import drps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               starve_limit_we,
  input  logic [LIMIT_W-1:0] starve_limit_data,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [SLOT_W-1:0]  slot_id,
  input  logic [CLOCK_W-1:0] arrival_clock,
  input  logic               cmd_ready,
  input  logic [CLOCK_W-1:0] now_clock,
  input  logic               last_entry,
  output logic               push,
  output entry_t             push_entry,
  input  logic               queue_full
);

  logic [LIMIT_W-1:0] starve_limit;
  logic               mid_pick;
  logic [CLOCK_W-1:0] pick_clock;
  logic [CLOCK_W-1:0] clk_sel;
  logic [CLOCK_W-1:0] cut;
  logic               over;

  assign req_ready = !queue_full;
  assign push      = req_valid && req_ready;

  // first entry of a pick brings its own clock
  assign clk_sel = mid_pick ? pick_clock : now_clock;
  assign over    = clk_sel > CLOCK_W'(starve_limit);
  assign cut     = clk_sel - CLOCK_W'(starve_limit);

  always_comb begin
    push_entry.slot    = slot_id;
    push_entry.arrival = arrival_clock;
    push_entry.ready   = cmd_ready;
    push_entry.starved = over && (arrival_clock < cut);
    push_entry.first   = !mid_pick;
    push_entry.last    = last_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      starve_limit <= STARVE_LIMIT_RESET;
      mid_pick     <= 1'b0;
      pick_clock   <= '0;
    end else begin
      if (starve_limit_we) begin
        starve_limit <= starve_limit_data;
      end
      if (push) begin
        mid_pick <= !last_entry;
        if (!mid_pick) begin
          pick_clock <= now_clock;
        end
      end
    end
  end

endmodule

### sv/drps_queue.sv
// short queue of classified entries between front and back
// depends on drps_pkg
module drps_queue
  import drps_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/drps_back.sv
// back part: folds the pairwise compare over entries and holds the result item
// depends on drps_pkg
module drps_back
  import drps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  entry_t            head_entry,
  output logic              pop,
  output logic              pick_valid,
  input  logic              pick_ready,
  output logic [SLOT_W-1:0] chosen_slot
);

  logic [SLOT_W-1:0]  win_slot;
  logic [CLOCK_W-1:0] win_arrival;
  logic               win_ready;
  logic               win_starved;
  logic               new_wins;
  logic               take;
  logic               out_free;

  assign out_free = !pick_valid || pick_ready;
  assign pop      = head_valid && (!head_entry.last || out_free);

  always_comb begin
    if (win_starved && head_entry.starved && (win_arrival != head_entry.arrival)) begin
      new_wins = head_entry.arrival < win_arrival;
    end else if (win_starved != head_entry.starved) begin
      new_wins = head_entry.starved;
    end else if (win_ready != head_entry.ready) begin
      new_wins = head_entry.ready;
    end else begin
      new_wins = head_entry.arrival < win_arrival;
    end
  end

  assign take = head_entry.first || new_wins;

  always_ff @(posedge clk) begin
    if (pop && take) begin
      win_slot    <= head_entry.slot;
      win_arrival <= head_entry.arrival;
      win_ready   <= head_entry.ready;
      win_starved <= head_entry.starved;
    end
    if (pop && head_entry.last) begin
      chosen_slot <= take ? head_entry.slot : win_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pick_valid <= 1'b0;
    end else if (pop && head_entry.last) begin
      pick_valid <= 1'b1;
    end else if (pick_ready) begin
      pick_valid <= 1'b0;
    end
  end

endmodule

### sv/dram_request_pick_frfcfs_starve_unit.sv
// top level of the fr-fcfs request picker with a starvation cap
// depends on drps_pkg, drps_front, drps_queue, drps_back
//
//   channel       handshake                        payload
//   request in    req_valid / req_ready            slot_id, arrival_clock, cmd_ready,
//                                                  now_clock, last_entry
//   pick out      pick_valid / pick_ready          chosen_slot
//   config        starve_limit_we                  starve_limit_data
//
// one buffer entry per cycle; after its last entry is accepted, the pick passes
// through the queue and then the output register before pick_valid rises
// the front only stalls when the queue is full; the back stalls only on a last
// entry while an earlier pick still waits at the output
// synchronous reset clears the pick state and sets starve_limit to 200
module dram_request_pick_frfcfs_starve_unit
  import drps_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               starve_limit_we,
  input  logic [LIMIT_W-1:0] starve_limit_data,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [SLOT_W-1:0]  slot_id,
  input  logic [CLOCK_W-1:0] arrival_clock,
  input  logic               cmd_ready,
  input  logic [CLOCK_W-1:0] now_clock,
  input  logic               last_entry,
  output logic               pick_valid,
  input  logic               pick_ready,
  output logic [SLOT_W-1:0]  chosen_slot
);

  logic   push;
  entry_t push_entry;
  logic   queue_full;
  logic   pop;
  logic   head_valid;
  entry_t head_entry;

  drps_front u_front (
    .clk               (clk),
    .rst               (rst),
    .starve_limit_we   (starve_limit_we),
    .starve_limit_data (starve_limit_data),
    .req_valid         (req_valid),
    .req_ready         (req_ready),
    .slot_id           (slot_id),
    .arrival_clock     (arrival_clock),
    .cmd_ready         (cmd_ready),
    .now_clock         (now_clock),
    .last_entry        (last_entry),
    .push              (push),
    .push_entry        (push_entry),
    .queue_full        (queue_full)
  );

  drps_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  drps_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_entry  (head_entry),
    .pop         (pop),
    .pick_valid  (pick_valid),
    .pick_ready  (pick_ready),
    .chosen_slot (chosen_slot)
  );

endmodule

### sim/dram_request_pick_frfcfs_starve_unit_test.sv
// self-checking bench for the fr-fcfs request picker with its starvation cap
// depends on drps_pkg and dram_request_pick_frfcfs_starve_unit
module dram_request_pick_frfcfs_starve_unit_test;
  import drps_pkg::*;

  typedef struct {
    logic [SLOT_W-1:0]  slot;
    logic [CLOCK_W-1:0] arrival;
    logic               rdy;
    logic [CLOCK_W-1:0] now;
    logic               last;
  } buf_entry_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               starve_limit_we = 1'b0;
  logic [LIMIT_W-1:0] starve_limit_data = '0;
  logic               req_valid = 1'b0;
  logic               req_ready;
  logic [SLOT_W-1:0]  slot_id = '0;
  logic [CLOCK_W-1:0] arrival_clock = '0;
  logic               cmd_ready = 1'b0;
  logic [CLOCK_W-1:0] now_clock = '0;
  logic               last_entry = 1'b0;
  logic               pick_valid;
  logic               pick_ready = 1'b0;
  logic [SLOT_W-1:0]  chosen_slot;

  dram_request_pick_frfcfs_starve_unit DUT (
    .clk               (clk),
    .rst               (rst),
    .starve_limit_we   (starve_limit_we),
    .starve_limit_data (starve_limit_data),
    .req_valid         (req_valid),
    .req_ready         (req_ready),
    .slot_id           (slot_id),
    .arrival_clock     (arrival_clock),
    .cmd_ready         (cmd_ready),
    .now_clock         (now_clock),
    .last_entry        (last_entry),
    .pick_valid        (pick_valid),
    .pick_ready        (pick_ready),
    .chosen_slot       (chosen_slot)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  buf_entry_t         pending_entries[$];
  logic [SLOT_W-1:0]  chosen_slot_due[$];

  // picker model state
  logic [LIMIT_W-1:0] starve_lim = STARVE_LIMIT_RESET;
  logic [SLOT_W-1:0]  held_slot = '0;
  logic [CLOCK_W-1:0] held_arrival = '0;
  logic               held_ready = 1'b0;
  logic [CLOCK_W-1:0] pick_clk = '0;
  logic               in_pick = 1'b0;

  int  fault_count = 0;
  int  entries_taken = 0;
  int  picks_checked = 0;
  int  limit_settings = 1;
  bit  calm = 1'b0;
  int  send_gap = 0;
  int  stall_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit entry_beats_held(logic [CLOCK_W-1:0] arr, logic rdy);
    logic [CLOCK_W-1:0] cut;
    bit held_st;
    bit new_st;
    if (pick_clk > CLOCK_W'(starve_lim)) begin
      cut = pick_clk - CLOCK_W'(starve_lim);
      held_st = held_arrival < cut;
      new_st = arr < cut;
      if (held_st && new_st) begin
        if (held_arrival < arr) return 1'b0;
        if (held_arrival > arr) return 1'b1;
      end else if (held_st) begin
        return 1'b0;
      end else if (new_st) begin
        return 1'b1;
      end
    end
    if (held_ready != rdy) return rdy;
    return arr < held_arrival;
  endfunction

  task automatic fold_entry(input buf_entry_t e);
    if (!in_pick || entry_beats_held(e.arrival, e.rdy)) begin
      held_slot = e.slot;
      held_arrival = e.arrival;
      held_ready = e.rdy;
    end
    // clock is taken from the first entry only
    if (!in_pick) pick_clk = e.now;
    if (e.last) chosen_slot_due.push_back(held_slot);
    in_pick = !e.last;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_valid <= 1'b0;
      end else if (pending_entries.size() != 0) begin
        buf_entry_t e;
        e = pending_entries.pop_front();
        slot_id <= e.slot;
        arrival_clock <= e.arrival;
        cmd_ready <= e.rdy;
        now_clock <= e.now;
        last_entry <= e.last;
        req_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      pick_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pick_ready <= 1'b0;
    end else begin
      pick_ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // monitor: predict on accepted entries, compare on accepted picks
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        buf_entry_t e;
        e.slot = slot_id;
        e.arrival = arrival_clock;
        e.rdy = cmd_ready;
        e.now = now_clock;
        e.last = last_entry;
        fold_entry(e);
        entries_taken++;
      end
      if (pick_valid && pick_ready) begin
        if (chosen_slot_due.size() == 0) begin
          $error("chosen_slot: unexpected item, actual %0d", chosen_slot);
          fault_count++;
        end else begin
          logic [SLOT_W-1:0] want;
          want = chosen_slot_due.pop_front();
          if (chosen_slot !== want) begin
            $error("chosen_slot: expected %0d, actual %0d", want, chosen_slot);
            fault_count++;
          end
          picks_checked++;
        end
      end
    end
  end

  task automatic queue_entry(input logic [SLOT_W-1:0] s, input logic [CLOCK_W-1:0] arr,
                             input logic rdy, input logic [CLOCK_W-1:0] now,
                             input logic last);
    buf_entry_t e;
    e.slot = s;
    e.arrival = arr;
    e.rdy = rdy;
    e.now = now;
    e.last = last;
    pending_entries.push_back(e);
  endtask

  // wait until every pick is back and the pipe is empty
  task automatic drain_picks();
    while (pending_entries.size() != 0 || req_valid || chosen_slot_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_starve_limit(input logic [LIMIT_W-1:0] v);
    drain_picks();
    starve_limit_we <= 1'b1;
    starve_limit_data <= v;
    @(posedge clk);
    starve_limit_we <= 1'b0;
    starve_lim = v;
    limit_settings++;
  endtask

  task automatic queue_random_pick(input int len);
    logic [CLOCK_W-1:0] now_v;
    logic [CLOCK_W-1:0] arr_v;
    logic [CLOCK_W-1:0] prev_arr;
    int span;
    span = 2 * int'(starve_lim) + 20;
    // now and then a small clock, at most twice the limit plus 20, that may not be above the limit
    now_v = ($urandom_range(0, 9) == 0) ? CLOCK_W'($urandom_range(0, span)) : $urandom;
    prev_arr = now_v;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    arr_v = $urandom;
        2, 3:    arr_v = prev_arr;
        default: arr_v = now_v - CLOCK_W'($urandom_range(0, span));
      endcase
      queue_entry(SLOT_W'($urandom), arr_v, 1'($urandom),
                  (i == 0) ? now_v : CLOCK_W'($urandom), i == len - 1);
      prev_arr = arr_v;
    end
  endtask

  initial begin
    logic [LIMIT_W-1:0] phase_limits[5];
    int n;
    int len;
    int r;
    phase_limits[0] = '0;
    phase_limits[1] = '1;
    phase_limits[2] = LIMIT_W'($urandom_range(1, 65534));
    phase_limits[3] = LIMIT_W'(1);
    phase_limits[4] = STARVE_LIMIT_RESET;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // field extremes as single-entry picks
    queue_entry('1, '1, 1'b1, '1, 1'b1);
    queue_entry('0, '0, 1'b0, '0, 1'b1);
    // readiness, age and tie order, arrival past the clock
    queue_entry(5'd5, 32'd900, 1'b0, 32'd1000, 1'b0);
    queue_entry(5'd6, 32'd950, 1'b1, 32'd7, 1'b0);
    queue_entry(5'd7, 32'd950, 1'b1, 32'd0, 1'b0);
    queue_entry(5'd8, 32'd920, 1'b1, 32'd3, 1'b0);
    queue_entry(5'd9, 32'd2000, 1'b0, 32'd5, 1'b1);
    // starving beats ready, older starving wins, equal starving falls to readiness
    queue_entry(5'd1, 32'd990, 1'b1, 32'd1000, 1'b0);
    queue_entry(5'd2, 32'd700, 1'b0, 32'd1000, 1'b0);
    queue_entry(5'd3, 32'd600, 1'b0, 32'd1000, 1'b0);
    queue_entry(5'd4, 32'd600, 1'b1, 32'd1000, 1'b1);
    // clock equal to the limit: nothing starves
    queue_entry(5'd10, 32'd50, 1'b0, 32'd200, 1'b0);
    queue_entry(5'd11, 32'd150, 1'b1, 32'd200, 1'b1);
    // arrival right at the cut is not starving, one below is
    queue_entry(5'd12, 32'd900, 1'b1, 32'd1000, 1'b0);
    queue_entry(5'd13, 32'd800, 1'b0, 32'd1000, 1'b1);
    queue_entry(5'd12, 32'd900, 1'b1, 32'd1000, 1'b0);
    queue_entry(5'd14, 32'd799, 1'b0, 32'd1000, 1'b1);
    set_starve_limit('0);
    queue_entry(5'd20, 32'd1, 1'b1, 32'd1, 1'b0);
    queue_entry(5'd21, 32'd0, 1'b0, 32'd1, 1'b1);
    set_starve_limit('1);
    queue_entry(5'd22, 32'd0, 1'b0, 32'd65535, 1'b0);
    queue_entry(5'd23, 32'd10, 1'b1, 32'd65535, 1'b1);
    queue_entry(5'd24, 32'd1, 1'b1, 32'd65537, 1'b0);
    queue_entry(5'd25, 32'd0, 1'b0, 32'd65537, 1'b1);

    for (int p = 0; p < 5; p++) begin
      set_starve_limit(phase_limits[p]);
      calm = (p == 2);
      n = 0;
      if (p == 1) begin
        // pick longer than the buffer
        queue_random_pick(40);
        n += 40;
      end
      while (n < 110) begin
        r = $urandom_range(0, 99);
        if (r < 85) len = $urandom_range(1, 8);
        else if (r < 97) len = $urandom_range(9, 32);
        else len = $urandom_range(33, 40);
        queue_random_pick(len);
        n += len;
      end
    end

    drain_picks();
    repeat (6) @(posedge clk);
    $display("accepted %0d buffer entries, checked %0d picks across %0d limit settings",
             entries_taken, picks_checked, limit_settings);
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
